// ----- hdl/jdpl_pkg.sv -----
// ----------------------------------------------------------------------------
// jdpl_pkg
// Shared constants, result kinds and the exp2 step coefficients used by the
// joystick null zone / power curve / limit pipeline.
// ----------------------------------------------------------------------------
package jdpl_pkg;

    // Default sample width (Q1.15 at 16 bits)
    localparam int SAMPLE_BITS_DEF = 16;
    // Exponent register width, unsigned Q3.8
    localparam int EXP_BITS = 11;
    // Exponent code for a linear curve (1.0 in Q3.8)
    localparam logic [EXP_BITS-1:0] EXP_UNITY = 11'd256;
    // Fraction bits of the log2 result and of the exponent split
    localparam int LOG_BITS = 24;
    // Fraction bits of the normalized mantissa and exp accumulator (Q1.30)
    localparam int ACC_FRAC = 30;
    localparam int ACC_W    = ACC_FRAC + 1;
    // Configuration register indexes
    localparam logic [1:0] CFG_NULL_ZONE = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_EXPONENT  = 2'd2;

    // How the final magnitude is formed
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,   // below null zone or zero remainder
        KIND_ONE  = 2'd1,   // exponent zero or full-scale remainder
        KIND_LIN  = 2'd2,   // linear curve, remainder passes through
        KIND_POW  = 2'd3    // log / scale / exp path
    } kind_t;

    // 2^(2^-k) in Q1.30, for exp2 step k
    function automatic logic [ACC_W-1:0] exp_coef(int k);
        logic [63:0] a;
        logic [63:0] c;
        begin
            a = 64'd744261118 >> k;   // ln2 * 2^30 / 2^k
            c = 64'd1073741824 + a + ((a * a) >> 31);
            case (k)
                1:       c = 64'd1518500250;
                2:       c = 64'd1276901418;
                3:       c = 64'd1170923762;
                4:       c = 64'd1121280437;
                5:       c = 64'd1097253708;
                6:       c = 64'd1085434107;
                7:       c = 64'd1079572136;
                8:       c = 64'd1076653033;
                default: c = c;
            endcase
            exp_coef = c[ACC_W-1:0];
        end
    endfunction

endpackage

// ----- hdl/joystick_deadzone_power_limit_core.sv -----
// ----------------------------------------------------------------------------
// joystick_deadzone_power_limit_core
// Null zone, power curve and magnitude limit for a signed joystick axis.
// ----------------------------------------------------------------------------
// One sample enters per clock while the output is not stalled, and one shaped
// sample leaves per sample, in order. The path has 2*24+5 register stages:
// two front stages, 24 log2 squaring stages, a multiply and a split stage,
// 24 exp2 stages and the output register. The curve is y = |x|-null_zone
// raised to curve_exponent/256 through log2, scaling and exp2; a stall on
// the output holds every stage at once. Configuration writes apply at once
// and are meant for an idle block.
module joystick_deadzone_power_limit_core #(
    parameter int SAMPLE_BITS = jdpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SB-1:0] sample_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SB-1:0] sample_out
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [((SAMPLE_BITS-1) > jdpl_pkg::EXP_BITS ? (SAMPLE_BITS-1)
                   : jdpl_pkg::EXP_BITS)-1:0]  cfg_data
);
    import jdpl_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = SB - 1;
    localparam int TDW  = ((SB + 7) / 8) * 8;
    localparam int IW   = $clog2(F + 1);
    localparam int NLW  = IW + LOG_BITS;
    localparam int TW   = NLW + EXP_BITS;
    localparam int T8W  = TW - 8;
    localparam int SHW  = T8W + 1 - LOG_BITS;
    localparam int D    = 2 * LOG_BITS + 4;
    localparam int MULI = LOG_BITS + 2;
    localparam logic [SB-1:0] ONE = SB'(1) << F;

    // Configuration registers
    logic [F-1:0]        null_zone_reg;
    logic [F-1:0]        limit_reg;
    logic [EXP_BITS-1:0] exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_zone_reg <= '0;
            limit_reg     <= '1;
            exp_reg       <= EXP_UNITY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NULL_ZONE: null_zone_reg <= cfg_data[F-1:0];
                CFG_LIMIT:     limit_reg     <= cfg_data[F-1:0];
                CFG_EXPONENT:  exp_reg       <= cfg_data[EXP_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Global advance: the whole pipe moves unless the output word is stuck
    logic ce;
    logic out_valid_reg;
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // Side line: valid, sign, kind, remainder and exponent per stage
    logic                vld_reg  [0:D-1];
    logic                neg_reg  [0:D-1];
    kind_t               kind_reg [0:D-1];
    logic [F-1:0]        r_reg    [0:D-1];
    logic [EXP_BITS-1:0] e_reg    [0:D-1];

    // Stage A: magnitude, null zone, special cases
    logic [SB-1:0] raw;
    logic          neg_a;
    logic [SB-1:0] mag_a;
    logic [SB-1:0] rem_a;
    kind_t         kind_a;

    always_comb
    begin
        raw   = s_tdata[SB-1:0];
        neg_a = raw[SB-1];
        mag_a = neg_a ? (SB'(0) - raw) : raw;
        rem_a = mag_a - {1'b0, null_zone_reg};
        if (mag_a < {1'b0, null_zone_reg})
            kind_a = KIND_ZERO;
        else if (exp_reg == '0 || rem_a[SB-1])
            kind_a = KIND_ONE;
        else if (rem_a == '0)
            kind_a = KIND_ZERO;
        else if (exp_reg == EXP_UNITY)
            kind_a = KIND_LIN;
        else
            kind_a = KIND_POW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= s_tvalid && s_tready;
            for (int i = 1; i < D; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_reg[0]  <= neg_a;
            kind_reg[0] <= kind_a;
            r_reg[0]    <= rem_a[F-1:0];
            e_reg[0]    <= exp_reg;
            for (int i = 1; i < D; i++)
            begin
                neg_reg[i]  <= neg_reg[i-1];
                kind_reg[i] <= kind_reg[i-1];
                r_reg[i]    <= r_reg[i-1];
                e_reg[i]    <= e_reg[i-1];
            end
        end
    end

    // Stage B: leading one and normalization into Q1.30
    logic [IW-1:0]       msb_b;
    logic [F-1:0]        norm_b;
    logic [ACC_W-1:0]    lx   [0:LOG_BITS];
    logic [LOG_BITS-1:0] lfr  [0:LOG_BITS];
    logic [IW-1:0]       lil  [0:LOG_BITS];

    always_comb
    begin
        msb_b = '0;
        for (int i = 0; i < F; i++)
            if (r_reg[0][i])
                msb_b = IW'(i);
        norm_b = r_reg[0] << (IW'(F - 1) - msb_b);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lx[0]  <= {norm_b, {(ACC_W-F){1'b0}}};
            lfr[0] <= '0;
            lil[0] <= IW'(F) - msb_b;
        end
    end

    // Log2 fraction, one bit per stage
    for (genvar k = 1; k <= LOG_BITS; k++)
    begin : g_log
        jdpl_log_stage #(.K(k), .IW(IW)) u_log (
            .clk      (clk),
            .ce       (ce),
            .x_in     (lx[k-1]),
            .frac_in  (lfr[k-1]),
            .ilog_in  (lil[k-1]),
            .x_out    (lx[k]),
            .frac_out (lfr[k]),
            .ilog_out (lil[k])
        );
    end

    // Multiply -log2 by the exponent
    logic [NLW-1:0] nlog;
    logic [TW-1:0]  t_reg;
    assign nlog = {lil[LOG_BITS], {LOG_BITS{1'b0}}} - {{IW{1'b0}}, lfr[LOG_BITS]};

    always_ff @(posedge clk)
    begin
        if (ce)
            t_reg <= nlog * e_reg[MULI-1];
    end

    // Split the scaled value into a right shift and an exp2 fraction
    logic [T8W-1:0]      t8;
    logic [T8W:0]        t_up;
    logic [ACC_W-1:0]    eacc [0:LOG_BITS];
    logic [LOG_BITS-1:0] eu   [0:LOG_BITS];
    logic [SHW-1:0]      esh  [0:LOG_BITS];

    assign t8   = t_reg[TW-1:8];
    assign t_up = {1'b0, t8} + {{(T8W+1-LOG_BITS){1'b0}}, {LOG_BITS{1'b1}}};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            eacc[0] <= ACC_W'(1) << ACC_FRAC;
            eu[0]   <= LOG_BITS'(0) - t8[LOG_BITS-1:0];
            esh[0]  <= t_up[T8W:LOG_BITS];
        end
    end

    // Exp2 of the fraction, one bit per stage
    for (genvar k = 1; k <= LOG_BITS; k++)
    begin : g_exp
        jdpl_exp_stage #(.K(k), .SHW(SHW)) u_exp (
            .clk     (clk),
            .ce      (ce),
            .acc_in  (eacc[k-1]),
            .u_in    (eu[k-1]),
            .sh_in   (esh[k-1]),
            .acc_out (eacc[k]),
            .u_out   (eu[k]),
            .sh_out  (esh[k])
        );
    end

    // Final shift with rounding, kind select, limit and sign
    logic [SHW:0]    tot_sh;
    logic [ACC_W-1:0] rnd;
    logic [ACC_W:0]  ypow;
    logic [SB:0]     ymag;
    logic [SB-1:0]   yout;

    always_comb
    begin
        tot_sh = {1'b0, esh[LOG_BITS]} + (SHW+1)'(ACC_FRAC - F);
        rnd    = '0;
        if (tot_sh <= (SHW+1)'(ACC_W))
            rnd = eacc[LOG_BITS] >> (tot_sh - (SHW+1)'(1));
        ypow = ({1'b0, rnd} + (ACC_W+1)'(1)) >> 1;
        case (kind_reg[D-1])
            KIND_ZERO: ymag = '0;
            KIND_ONE:  ymag = {1'b0, ONE};
            KIND_LIN:  ymag = {2'b00, r_reg[D-1]};
            KIND_POW:  ymag = ypow[SB:0];
            default:   ymag = '0;
        endcase
        if (ymag > {2'b00, limit_reg})
            ymag = {2'b00, limit_reg};
        yout = neg_reg[D-1] ? (SB'(0) - ymag[SB-1:0]) : ymag[SB-1:0];
    end

    // Output word register
    logic [SB-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= vld_reg[D-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_data_reg <= yout;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_data_reg);

endmodule

// ----- hdl/jdpl_log_stage.sv -----
// ----------------------------------------------------------------------------
// jdpl_log_stage
// One bit of the log2 fraction by squaring the normalized mantissa.
// ----------------------------------------------------------------------------
module jdpl_log_stage #(
    parameter int K  = 1,
    parameter int IW = 4
) (
    input  logic                              clk,
    input  logic                              ce,
    input  logic [jdpl_pkg::ACC_W-1:0]        x_in,
    input  logic [jdpl_pkg::LOG_BITS-1:0]     frac_in,
    input  logic [IW-1:0]                     ilog_in,
    output logic [jdpl_pkg::ACC_W-1:0]        x_out,
    output logic [jdpl_pkg::LOG_BITS-1:0]     frac_out,
    output logic [IW-1:0]                     ilog_out
);
    import jdpl_pkg::*;

    logic [2*ACC_W-1:0]  sq;
    logic [ACC_W-1:0]    x_next;
    logic [LOG_BITS-1:0] frac_next;

    // Square, renormalize into [1,2) and record the bit
    always_comb
    begin
        sq        = x_in * x_in;
        frac_next = frac_in;
        frac_next[LOG_BITS-K] = sq[2*ACC_W-1];
        if (sq[2*ACC_W-1])
            x_next = sq[2*ACC_W-1:ACC_FRAC+1];
        else
            x_next = sq[2*ACC_W-2:ACC_FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_out    <= x_next;
            frac_out <= frac_next;
            ilog_out <= ilog_in;
        end
    end

endmodule

// ----- hdl/jdpl_exp_stage.sv -----
// ----------------------------------------------------------------------------
// jdpl_exp_stage
// One step of exp2 of a fraction: multiply by 2^(2^-K) where that bit is set.
// ----------------------------------------------------------------------------
module jdpl_exp_stage #(
    parameter int K   = 1,
    parameter int SHW = 8
) (
    input  logic                              clk,
    input  logic                              ce,
    input  logic [jdpl_pkg::ACC_W-1:0]        acc_in,
    input  logic [jdpl_pkg::LOG_BITS-1:0]     u_in,
    input  logic [SHW-1:0]                    sh_in,
    output logic [jdpl_pkg::ACC_W-1:0]        acc_out,
    output logic [jdpl_pkg::LOG_BITS-1:0]     u_out,
    output logic [SHW-1:0]                    sh_out
);
    import jdpl_pkg::*;

    localparam logic [ACC_W-1:0] COEF = exp_coef(K);

    logic [2*ACC_W-1:0] prod;
    logic [ACC_W-1:0]   acc_next;

    // Scale the accumulator by this step's constant when its fraction bit is set
    always_comb
    begin
        prod = acc_in * COEF;
        if (u_in[LOG_BITS-K])
            acc_next = prod[ACC_FRAC+ACC_W-1:ACC_FRAC];
        else
            acc_next = acc_in;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            acc_out <= acc_next;
            u_out   <= u_in;
            sh_out  <= sh_in;
        end
    end

endmodule

// ----- hdl/jdpl_checker.sv -----
// ----------------------------------------------------------------------------
// jdpl_checker
// Port-level checks on the shaping core, attached by bind.
// ----------------------------------------------------------------------------
module jdpl_checker #(
    parameter int SAMPLE_BITS = jdpl_pkg::SAMPLE_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata
);

    // Hold a stalled output word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Empty output side never blocks the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // A taken output word frees the input side in the same cycle
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // Nothing leaves right after reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid out of reset");

endmodule

bind joystick_deadzone_power_limit_core jdpl_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_jdpl_checker (.*);
